FILE: rtl/pcd_pkg.sv
package pcd_pkg;

  // input item modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  // widths of the mask used when comparing codewords
  localparam int unsigned CMP_W = 16;

  typedef struct packed {
    logic       mode;
    logic [7:0] entry_symbol;
    logic [7:0] entry_code;
    logic [3:0] entry_length;
    logic       coded_bit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] decoded_symbol;
    logic [1:0] status;
  } out_item_t;

  // one stored table entry
  typedef struct packed {
    logic [7:0] symbol;
    logic [7:0] code;
    logic [3:0] length;
  } table_entry_t;

endpackage

FILE: rtl/pcd_ram.sv
module pcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/pcd_seq.sv
module pcd_seq
  import pcd_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH  = 128,
  parameter int unsigned MAX_CODE_LEN = 8,
  parameter int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  in_item_t     in_item,
  output logic         res_vld,
  output out_item_t    res_item,
  input  logic         res_take,
  output logic         ram_we,
  output logic [AW-1:0] ram_waddr,
  output table_entry_t ram_wdata,
  output logic [AW-1:0] ram_raddr,
  input  table_entry_t ram_rdata
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LW = $clog2(MAX_CODE_LEN + 1);
  localparam int unsigned MW = MAX_CODE_LEN;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [MW-1:0] pbits_r, pbits_nxt;
  logic [LW-1:0] plen_r, plen_nxt;
  logic [AW-1:0] raddr_r, raddr_nxt;
  out_item_t     res_r, res_nxt;

  logic             accept;
  logic [CMP_W-1:0] len_mask;
  logic [CMP_W-1:0] code_cmp;
  logic [CMP_W-1:0] pend_cmp;
  logic             hit;
  logic             last;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // compare the entry on the read port with the pending buffer
  assign len_mask = (CMP_W'(1) << ram_rdata.length) - CMP_W'(1);
  assign code_cmp = CMP_W'(ram_rdata.code) & len_mask;
  assign pend_cmp = CMP_W'(pbits_r);
  assign hit      = (ram_rdata.length != 4'd0)
                 && (5'(ram_rdata.length) == 5'(plen_r))
                 && (code_cmp == pend_cmp);
  assign last     = (CW'(raddr_r) + CW'(1)) == count_r;

  // table write port: loads land at the fill count
  assign ram_waddr = count_r[AW-1:0];
  assign ram_wdata = '{symbol: in_item.entry_symbol,
                       code:   in_item.entry_code,
                       length: in_item.entry_length};

  // read address runs one entry ahead of the compare
  assign ram_raddr = (state_r == ST_SCAN) ? (raddr_r + AW'(1)) : '0;

  assign res_vld  = (state_r == ST_RESULT);
  assign res_item = res_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pbits_nxt = pbits_r;
    plen_nxt  = plen_r;
    raddr_nxt = raddr_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          raddr_nxt = '0;
          if (in_item.mode == MODE_LOAD) begin
            if (count_r == CW'(TABLE_DEPTH)) begin
              res_nxt   = '{decoded_symbol: 8'd0, status: STATUS_FULL};
              state_nxt = ST_RESULT;
            end else begin
              ram_we    = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end else if (plen_r == LW'(MAX_CODE_LEN)) begin
            pbits_nxt = '0;
            plen_nxt  = '0;
            res_nxt   = '{decoded_symbol: 8'd0, status: STATUS_OVERFLOW};
            state_nxt = ST_RESULT;
          end else begin
            pbits_nxt = (pbits_r << 1) | MW'(in_item.coded_bit);
            plen_nxt  = plen_r + LW'(1);
            if (count_r != '0) begin
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          pbits_nxt = '0;
          plen_nxt  = '0;
          res_nxt   = '{decoded_symbol: ram_rdata.symbol, status: STATUS_OK};
          state_nxt = ST_RESULT;
        end else if (last) begin
          state_nxt = ST_IDLE;
        end else begin
          raddr_nxt = raddr_r + AW'(1);
        end
      end
      ST_RESULT: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      pbits_r <= '0;
      plen_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pbits_r <= pbits_nxt;
      plen_r  <= plen_nxt;
    end
  end

  // scan index and held result
  always_ff @(posedge clk) begin
    raddr_r <= raddr_nxt;
    res_r   <= res_nxt;
  end

endmodule

FILE: rtl/prefix_code_table_decoder_top.sv
// Prefix code table decoder. Load items (mode 0) append a symbol and its
// codeword to a table held in a single-port-read RAM; a load into a full
// table is dropped and answered with status 2. Decode items (mode 1) shift
// one bit into a pending buffer and then walk the loaded entries in load
// order, one RAM read per cycle, until the first entry of equal length and
// bits is found; that entry's symbol is returned with status 0 and the
// buffer is cleared. A bit arriving on a full buffer clears it and returns
// status 1. A load into a table with room does not stall the input; the input
// is stalled while a decode walks the table and while a result waits to be
// handed to the output register. The table walk through the RAM read port
// sets the decode rate. The table contents are not cleared at reset; only
// entries already loaded are read.
module prefix_code_table_decoder_top
  import pcd_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH  = 128,
  parameter int unsigned MAX_CODE_LEN = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic         ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  table_entry_t ram_wdata;
  table_entry_t ram_rdata;
  logic [$bits(table_entry_t)-1:0] ram_rdata_raw;

  logic      res_vld;
  logic      res_take;
  out_item_t res_item;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  // codeword table
  pcd_ram #(
    .WIDTH ($bits(table_entry_t)),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = table_entry_t'(ram_rdata_raw);

  // load and decode sequencer
  pcd_seq #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .AW           (AW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .res_vld   (res_vld),
    .res_item  (res_item),
    .res_take  (res_take),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // output register takes a result when empty or when its transfer completes
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_vld) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: rtl/pcd_checker.sv
module pcd_checker
  import pcd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == STATUS_OK
                || out_item.status == STATUS_OVERFLOW
                || out_item.status == STATUS_FULL))
    else $error("undefined status code");

  // error results carry a zero symbol
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != STATUS_OK) |-> out_item.decoded_symbol == 8'd0)
    else $error("error result with nonzero symbol");

  // a new result follows a cycle in which the input side was held off
  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a busy cycle");

  // the block is ready for input right after reset
  a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_stall)
    else $error("input held off after reset");

endmodule

bind prefix_code_table_decoder_top pcd_checker u_pcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

FILE: tb/tb_prefix_code_table_decoder_top.sv
`timescale 1ns / 100ps

module tb_prefix_code_table_decoder_top;
  import pcd_pkg::*;

  localparam int unsigned TBL_DEPTH = 128;
  localparam int unsigned CODE_MAX  = 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  prefix_code_table_decoder_top #(
    .TABLE_DEPTH (TBL_DEPTH),
    .MAX_CODE_LEN(CODE_MAX)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // items waiting to be sent, and results still to come
  in_item_t    item_queue[$];
  out_item_t   awaited_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bad_results = 0;
  int unsigned queued_items = 0;

  // shadow of the codeword table and the pending bit buffer
  logic [7:0]  tbl_sym  [TBL_DEPTH];
  logic [7:0]  tbl_code [TBL_DEPTH];
  logic [3:0]  tbl_len  [TBL_DEPTH];
  int unsigned tbl_count = 0;
  logic [7:0]  buf_bits = '0;
  int unsigned buf_len = 0;

  // generator view of what has been loaded, to build valid codeword streams
  logic [7:0]  sent_code [TBL_DEPTH];
  logic [3:0]  sent_len  [TBL_DEPTH];
  int unsigned sent_count = 0;
  int          usable[$];

  // predict one accepted transfer; a decode walks the table in load order
  task automatic table_walk_predict(input in_item_t it);
    out_item_t   r;
    logic [7:0]  lmask;
    bit          hit;
    int unsigned k;
    hit = 1'b0;
    if (it.mode == MODE_LOAD) begin
      if (tbl_count >= TBL_DEPTH) begin
        r.decoded_symbol = 8'd0;
        r.status = STATUS_FULL;
        awaited_results.push_back(r);
      end else begin
        tbl_sym[tbl_count] = it.entry_symbol;
        tbl_code[tbl_count] = it.entry_code;
        tbl_len[tbl_count] = it.entry_length;
        tbl_count++;
      end
    end else if (buf_len >= CODE_MAX) begin
      // bit lands on a full buffer: both are dropped
      buf_bits = '0;
      buf_len = 0;
      r.decoded_symbol = 8'd0;
      r.status = STATUS_OVERFLOW;
      awaited_results.push_back(r);
    end else begin
      buf_bits = {buf_bits[6:0], it.coded_bit};
      buf_len++;
      for (k = 0; k < tbl_count && !hit; k++) begin
        if (tbl_len[k] != 0 && tbl_len[k] == buf_len) begin
          lmask = 8'((9'd1 << tbl_len[k]) - 9'd1);
          if ((tbl_code[k] & lmask) == buf_bits) begin
            hit = 1'b1;
            r.decoded_symbol = tbl_sym[k];
            r.status = STATUS_OK;
            awaited_results.push_back(r);
            buf_bits = '0;
            buf_len = 0;
          end
        end
      end
    end
  endtask

  task automatic push_load(input logic [7:0] sym, input logic [7:0] code,
                           input logic [3:0] len);
    in_item_t it;
    it.mode = MODE_LOAD;
    it.entry_symbol = sym;
    it.entry_code = code;
    it.entry_length = len;
    it.coded_bit = 1'($urandom);
    item_queue.push_back(it);
    queued_items++;
    if (sent_count < TBL_DEPTH) begin
      sent_code[sent_count] = code;
      sent_len[sent_count] = len;
      if (len != 0 && len <= CODE_MAX) usable.push_back(sent_count);
    end
    sent_count++;
  endtask

  // decode transfer; the unused fields carry random junk
  task automatic push_bit(input logic b);
    in_item_t it;
    it.mode = MODE_DECODE;
    it.entry_symbol = 8'($urandom);
    it.entry_code = 8'($urandom);
    it.entry_length = 4'($urandom);
    it.coded_bit = b;
    item_queue.push_back(it);
    queued_items++;
  endtask

  // codeword bits, first bit most significant
  task automatic push_code(input logic [7:0] code, input int len);
    int k;
    for (k = len - 1; k >= 0; k--) push_bit(code[k]);
  endtask

  task automatic add_random_sequence();
    int unsigned pick;
    int unsigned n;
    int          idx;
    logic [3:0]  len;
    pick = $urandom_range(99);
    if (pick < ((sent_count < TBL_DEPTH) ? 30 : 6)) begin
      // mostly usable lengths, some zero and some too long
      n = $urandom_range(9);
      if (n == 0) len = 4'd0;
      else if (n == 1) len = 4'($urandom_range(15, 9));
      else len = 4'($urandom_range(8, 1));
      push_load(8'($urandom), 8'($urandom), len);
    end else if (pick < 75 && usable.size() > 0) begin
      idx = usable[$urandom_range(usable.size() - 1)];
      push_code(sent_code[idx], sent_len[idx]);
    end else if (pick < 85 && usable.size() > 0) begin
      // truncated codeword, leaves stale bits in the buffer
      idx = usable[$urandom_range(usable.size() - 1)];
      n = $urandom_range(sent_len[idx] - 1, 0);
      if (n > 0) push_code(sent_code[idx] >> (sent_len[idx] - n), n);
    end else if (pick < 95) begin
      n = $urandom_range(3, 1);
      repeat (n) push_bit(1'($urandom));
    end else begin
      // long run of noise, likely to overflow the buffer
      repeat (CODE_MAX + 1) push_bit(1'($urandom));
    end
  endtask

  // driver: present queued items, hold while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) table_walk_predict(in_item);
      if (!in_valid || !in_stall) begin
        if (item_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item <= item_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("%0t: unexpected result symbol=%02h status=%0d", $time,
                   out_item.decoded_symbol, out_item.status);
      end else begin
        want = awaited_results.pop_front();
        if (out_item.decoded_symbol !== want.decoded_symbol ||
            out_item.status !== want.status) begin
          bad_results++;
          if (bad_results <= 10)
            $display("%0t: result mismatch symbol exp=%02h got=%02h status exp=%0d got=%0d",
                     $time, want.decoded_symbol, out_item.decoded_symbol,
                     want.status, out_item.status);
        end
      end
    end
  end

  // stimulus phases with different idle and stall mixes
  initial begin
    int unsigned phase_end [4];
    int unsigned send_mix [4];
    int unsigned recv_mix [4];
    int          ph;
    phase_end = '{490, 980, 1465, 1950};
    send_mix = '{0, 71, 0, 34};
    recv_mix = '{0, 0, 71, 34};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      send_idle_pct <= send_mix[ph];
      recv_stall_pct <= recv_mix[ph];
      if (ph == 0) begin
        // all-ones length 8, upper code bits ignored, zero length, too long,
        // duplicate codeword that must lose to the earlier entry
        push_load(8'hA5, 8'hFF, 4'd8);
        push_load(8'h00, 8'hF2, 4'd2);
        push_load(8'hFF, 8'h00, 4'd0);
        push_load(8'h3C, 8'h55, 4'd15);
        push_load(8'h11, 8'h02, 4'd2);
        push_code(8'h02, 2);
        push_code(8'hFF, 8);
        // nine zeros match nothing, the last one overflows
        repeat (CODE_MAX + 1) push_bit(1'b0);
      end
      while (queued_items < phase_end[ph]) add_random_sequence();
      // sender holds off until every result is back and the walk is over
      while (item_queue.size() != 0 || in_valid || awaited_results.size() != 0)
        @(negedge clk);
      repeat (TBL_DEPTH + 8) @(posedge clk);
    end
    bad_results += awaited_results.size();
    if (bad_results == 0) begin
      $display("PASS prefix_code_table_decoder_top");
    end else begin
      $display("FAIL prefix_code_table_decoder_top");
    end
    $finish;
  end

  // watchdog
  initial begin
    #25_000_000;
    $display("FAIL prefix_code_table_decoder_top");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pcd_pkg.sv
rtl/pcd_ram.sv
rtl/pcd_seq.sv
rtl/prefix_code_table_decoder_top.sv
rtl/pcd_checker.sv
tb/tb_prefix_code_table_decoder_top.sv
